FILE: src/tnw_pkg.sv
// shared types and constants for the text number to word byte converter
package tnw_pkg;

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_ZERO,
        MODE_DEC,
        MODE_HEX,
        MODE_HALT
    } t_mode;

    typedef enum logic [1:0] {
        ST_DATA,
        ST_BAD_CHAR,
        ST_BAD_VALUE
    } t_status;

    localparam logic [1:0] BO_HOST   = 2'd0;
    localparam logic [1:0] BO_LITTLE = 2'd1;
    localparam logic [1:0] BO_BIG    = 2'd2;

    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    localparam int unsigned WORD_W = 32;

    // one finished token handed from the parser to the serializer
    typedef struct packed {
        logic              is_err;
        t_status           status;
        logic [WORD_W-1:0] value;
    } t_evt;

endpackage

FILE: src/tnw_ifs.sv
// channel interfaces for text bytes in, word bytes out and the configuration write

interface tnw_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

interface tnw_word_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_word;
    logic [1:0] status;

    modport source (output valid, output out_byte, output last_of_word, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_word, input status,
                    output ready);
endinterface

interface tnw_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] byte_order;

    modport source (output valid, output byte_order, input ready);
    modport sink   (input valid, input byte_order, output ready);
endinterface

FILE: src/tnw_parse.sv
// token parser: mode and accumulator update per text beat, one pending word slot
module tnw_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tnw_char_if.sink          i_char,
    output logic              o_evt_valid,
    output tnw_pkg::t_evt     o_evt,
    input  logic              i_evt_ready
);

    tnw_pkg::t_mode     r_mode, n_mode;
    logic [31:0]        r_acc, n_acc;
    logic               r_evt_valid, n_evt_valid;
    tnw_pkg::t_evt      r_evt, n_evt;

    logic               take;
    logic               produce;
    tnw_pkg::t_evt      evt;
    logic [7:0]         ch;
    logic               eoi;
    logic               is_space;
    logic               is_dec;
    logic               is_hex;
    logic [3:0]         hex_val;
    logic [31:0]        acc_x10;

    assign ch  = i_char.char_code;
    assign eoi = i_char.end_of_input;

    assign i_char.ready = !r_evt_valid || i_evt_ready;
    assign take         = i_char.valid && i_char.ready;

    always_comb begin
        is_space = (ch == tnw_pkg::CH_SPACE) || (ch >= tnw_pkg::CH_TAB && ch <= tnw_pkg::CH_CR);
        is_dec   = (ch >= tnw_pkg::CH_ZERO && ch <= tnw_pkg::CH_NINE);
        is_hex   = is_dec
                || (ch >= tnw_pkg::CH_LO_A && ch <= tnw_pkg::CH_LO_F)
                || (ch >= tnw_pkg::CH_UP_A && ch <= tnw_pkg::CH_UP_F);
        // letters a-f / A-F have low nibble 1..6
        hex_val  = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);
        acc_x10  = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {28'd0, ch[3:0]};
    end

    always_comb begin
        n_mode       = r_mode;
        n_acc        = r_acc;
        produce      = 1'b0;
        evt.is_err   = 1'b0;
        evt.status   = tnw_pkg::ST_DATA;
        evt.value    = r_acc;
        unique case (r_mode) inside
            tnw_pkg::MODE_SKIP: begin
                if (!eoi && !is_space) begin
                    if (ch == tnw_pkg::CH_COMMA) begin
                        // empty token
                        produce   = 1'b1;
                        evt.value = '0;
                        n_acc     = '0;
                    end else if (ch == tnw_pkg::CH_ZERO) begin
                        n_acc  = '0;
                        n_mode = tnw_pkg::MODE_ZERO;
                    end else if (ch >= tnw_pkg::CH_ONE && ch <= tnw_pkg::CH_NINE) begin
                        n_acc  = {28'd0, ch[3:0]};
                        n_mode = tnw_pkg::MODE_DEC;
                    end else begin
                        produce    = 1'b1;
                        evt.is_err = 1'b1;
                        evt.status = tnw_pkg::ST_BAD_CHAR;
                        n_mode     = tnw_pkg::MODE_HALT;
                    end
                end
            end
            tnw_pkg::MODE_ZERO: begin
                if (!eoi && ch == tnw_pkg::CH_X) begin
                    n_acc  = '0;
                    n_mode = tnw_pkg::MODE_HEX;
                end else begin
                    produce    = 1'b1;
                    evt.is_err = 1'b1;
                    evt.status = tnw_pkg::ST_BAD_VALUE;
                    n_mode     = tnw_pkg::MODE_HALT;
                end
            end
            tnw_pkg::MODE_DEC, tnw_pkg::MODE_HEX: begin
                if (eoi) begin
                    produce    = 1'b1;
                    evt.is_err = 1'b1;
                    evt.status = tnw_pkg::ST_BAD_CHAR;
                    n_mode     = tnw_pkg::MODE_HALT;
                end else if (ch == tnw_pkg::CH_COMMA || is_space) begin
                    produce = 1'b1;
                    n_acc   = '0;
                    n_mode  = tnw_pkg::MODE_SKIP;
                end else if (r_mode == tnw_pkg::MODE_DEC && is_dec) begin
                    n_acc = acc_x10;
                end else if (r_mode == tnw_pkg::MODE_HEX && is_hex) begin
                    n_acc = {r_acc[27:0], hex_val};
                end else begin
                    produce    = 1'b1;
                    evt.is_err = 1'b1;
                    evt.status = tnw_pkg::ST_BAD_CHAR;
                    n_mode     = tnw_pkg::MODE_HALT;
                end
            end
            tnw_pkg::MODE_HALT: begin
                n_mode = tnw_pkg::MODE_HALT;
            end
            default: begin
                n_mode = tnw_pkg::MODE_HALT;
            end
        endcase
    end

    always_comb begin
        n_evt_valid = r_evt_valid && !i_evt_ready;
        n_evt       = r_evt;
        if (take && produce) begin
            n_evt_valid = 1'b1;
            n_evt       = evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= tnw_pkg::MODE_SKIP;
            r_acc       <= '0;
            r_evt_valid <= 1'b0;
        end else begin
            r_evt_valid <= n_evt_valid;
            if (take) begin
                r_mode <= n_mode;
                r_acc  <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_evt <= n_evt;
    end

    assign o_evt_valid = r_evt_valid;
    assign o_evt       = r_evt;

endmodule

FILE: src/tnw_serial.sv
// word serializer: turns one token result into four byte beats or one error beat
module tnw_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_evt_valid,
    input  tnw_pkg::t_evt     i_evt,
    output logic              o_evt_ready,
    input  logic [1:0]        i_byte_order,
    tnw_word_if.source        o_word
);

    logic              r_valid, n_valid;
    logic [31:0]       r_shift, n_shift;
    logic [1:0]        r_left, n_left;
    tnw_pkg::t_status  r_status, n_status;

    logic              beat_done;
    logic              load;

    assign beat_done   = o_word.valid && o_word.ready;
    assign o_evt_ready = !r_valid || (beat_done && r_left == 2'd0);
    assign load        = i_evt_valid && o_evt_ready;

    always_comb begin
        n_valid  = r_valid;
        n_shift  = r_shift;
        n_left   = r_left;
        n_status = r_status;
        if (beat_done) begin
            n_shift = {8'd0, r_shift[31:8]};
            n_left  = r_left - 2'd1;
            if (r_left == 2'd0) begin
                n_valid = 1'b0;
            end
        end
        if (load) begin
            n_valid  = 1'b1;
            n_status = i_evt.status;
            if (i_evt.is_err) begin
                n_shift = '0;
                n_left  = 2'd0;
            end else begin
                n_left = 2'd3;
                // low byte always goes out first, so swap up front for big-endian
                if (i_byte_order == tnw_pkg::BO_BIG) begin
                    n_shift = {i_evt.value[7:0], i_evt.value[15:8],
                               i_evt.value[23:16], i_evt.value[31:24]};
                end else begin
                    n_shift = i_evt.value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_left   <= n_left;
        r_status <= n_status;
    end

    assign o_word.valid        = r_valid;
    assign o_word.out_byte     = r_shift[7:0];
    assign o_word.last_of_word = (r_left == 2'd0);
    assign o_word.status       = r_status;

endmodule

FILE: src/text_number_to_word_bytes.sv
// top level of the text number to word byte converter
//
// Takes one text byte per beat on i_char and turns comma or whitespace separated
// decimal and 0x hex tokens into 32-bit words, sent as four byte beats on o_word
// (little-endian for byte_order 0, 1 and 3, big-endian for 2). A comma between
// tokens gives a zero word. A bad character, a leading 0 not followed by x, or end
// of input inside a token gives one error beat with last_of_word set, after which
// the converter swallows all input until reset. Text beats are taken one per cycle
// while the parser's word slot is free; each word drains at one byte beat per cycle
// while o_word is ready, and the input side stalls only when a second finished word
// is waiting behind one still draining. There is no clearing pass after reset. The
// user must write byte_order on i_cfg (always ready) while idle; nothing enforces it.
module text_number_to_word_bytes (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tnw_cfg_if.sink     i_cfg,
    tnw_char_if.sink    i_char,
    tnw_word_if.source  o_word
);

    // byte order register, reset to host order
    logic [1:0]     r_byte_order;

    // parser to serializer hand-off
    logic           evt_valid;
    logic           evt_ready;
    tnw_pkg::t_evt  evt;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order <= tnw_pkg::BO_HOST;
        end else if (i_cfg.valid) begin
            r_byte_order <= i_cfg.byte_order;
        end
    end

    // per-byte token parsing with a one-word holding slot
    tnw_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_char),
        .o_evt_valid (evt_valid),
        .o_evt       (evt),
        .i_evt_ready (evt_ready)
    );

    // byte beat generation from the output register
    tnw_serial u_serial (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_evt_valid  (evt_valid),
        .i_evt        (evt),
        .o_evt_ready  (evt_ready),
        .i_byte_order (r_byte_order),
        .o_word       (o_word)
    );

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for the text number to word byte converter
module tb_top;

    // whitespace bytes the package does not name
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_VT = 8'h0b;
    localparam logic [7:0] CH_FF = 8'h0c;

    // the undefined byte order code, expected to behave as host order
    localparam logic [1:0] BO_UNDEF = 2'd3;

    localparam int unsigned RANDOM_BEATS  = 260;
    localparam int unsigned ORDER_PHASES  = 5;
    // parser update plus serializer hand-off, with margin
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned REPORT_MAX    = 10;

    // one expected beat on the word side
    typedef struct {
        logic [7:0]       out_byte;
        logic             last_of_word;
        tnw_pkg::t_status status;
    } t_out_beat;

    logic clk;
    logic rst_n;

    tnw_cfg_if  cfg_if ();
    tnw_char_if char_if ();
    tnw_word_if word_if ();

    text_number_to_word_bytes dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_char  (char_if),
        .o_word  (word_if)
    );

    // shadow of the converter: parse state, running number, byte order
    tnw_pkg::t_mode text_mode;
    logic [31:0]    number_acc;
    logic [1:0]     word_order;

    // word byte beats still owed by the converter, oldest first
    t_out_beat   word_beats_due[$];
    t_out_beat   beat_due;

    int unsigned mismatch_count = 0;
    int unsigned text_beats_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;
    int unsigned ready_tick = 0;
    int unsigned ready_mode = 0;

    // 20 unit clock period
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // generous watchdog so a hung handshake still ends the run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // tab, line feed, vertical tab, form feed, carriage return and space
    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == tnw_pkg::CH_SPACE) || (ch >= tnw_pkg::CH_TAB && ch <= tnw_pkg::CH_CR);
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] ch);
        return ch >= tnw_pkg::CH_ZERO && ch <= tnw_pkg::CH_NINE;
    endfunction

    // {valid, value} of a hex digit in either case
    function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'd0;
        if (is_dec_digit(ch)) begin
            d = ch - tnw_pkg::CH_ZERO;
        end else if (ch >= tnw_pkg::CH_LO_A && ch <= tnw_pkg::CH_LO_F) begin
            d = ch - tnw_pkg::CH_LO_A + 8'd10;
        end else if (ch >= tnw_pkg::CH_UP_A && ch <= tnw_pkg::CH_UP_F) begin
            d = ch - tnw_pkg::CH_UP_A + 8'd10;
        end else begin
            return 5'd0;
        end
        return {1'b1, d[3:0]};
    endfunction

    // four byte beats of one word, big-endian only for BO_BIG
    function automatic void queue_word(input logic [31:0] value);
        t_out_beat b;
        for (int k = 0; k < 4; k++) begin
            b.out_byte     = (word_order == tnw_pkg::BO_BIG) ? value[8*(3-k) +: 8]
                                                             : value[8*k +: 8];
            b.last_of_word = (k == 3);
            b.status       = tnw_pkg::ST_DATA;
            word_beats_due.push_back(b);
        end
    endfunction

    // one error beat, then the converter goes dead until reset
    function automatic void queue_error(input tnw_pkg::t_status code);
        t_out_beat b;
        b.out_byte     = 8'h00;
        b.last_of_word = 1'b1;
        b.status       = code;
        word_beats_due.push_back(b);
        text_mode = tnw_pkg::MODE_HALT;
    endfunction

    // advance the shadow parser by one accepted text beat
    function automatic void predict_text_byte(input logic [7:0] ch, input logic eoi);
        logic [4:0] nib;
        case (text_mode)
            tnw_pkg::MODE_SKIP: begin
                // end of input and blanks between tokens are simply skipped
                if (!(eoi || is_blank(ch))) begin
                    if (ch == tnw_pkg::CH_COMMA) begin
                        number_acc = 32'd0;
                        queue_word(32'd0);
                    end else if (ch == tnw_pkg::CH_ZERO) begin
                        number_acc = 32'd0;
                        text_mode  = tnw_pkg::MODE_ZERO;
                    end else if (ch >= tnw_pkg::CH_ONE && ch <= tnw_pkg::CH_NINE) begin
                        number_acc = 32'(ch - tnw_pkg::CH_ZERO);
                        text_mode  = tnw_pkg::MODE_DEC;
                    end else begin
                        queue_error(tnw_pkg::ST_BAD_CHAR);
                    end
                end
            end
            tnw_pkg::MODE_ZERO: begin
                if (!eoi && ch == tnw_pkg::CH_X) begin
                    number_acc = 32'd0;
                    text_mode  = tnw_pkg::MODE_HEX;
                end else begin
                    queue_error(tnw_pkg::ST_BAD_VALUE);
                end
            end
            tnw_pkg::MODE_DEC, tnw_pkg::MODE_HEX: begin
                nib = hex_nibble(ch);
                if (eoi) begin
                    queue_error(tnw_pkg::ST_BAD_CHAR);
                end else if (ch == tnw_pkg::CH_COMMA || is_blank(ch)) begin
                    queue_word(number_acc);
                    number_acc = 32'd0;
                    text_mode  = tnw_pkg::MODE_SKIP;
                end else if (text_mode == tnw_pkg::MODE_DEC) begin
                    if (is_dec_digit(ch)) begin
                        number_acc = number_acc * 32'd10 + 32'(ch - tnw_pkg::CH_ZERO);
                    end else begin
                        queue_error(tnw_pkg::ST_BAD_CHAR);
                    end
                end else if (nib[4]) begin
                    number_acc = {number_acc[27:0], nib[3:0]};
                end else begin
                    queue_error(tnw_pkg::ST_BAD_CHAR);
                end
            end
            default: begin
                text_mode = tnw_pkg::MODE_HALT;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // word side: stall pattern and checking
    // ------------------------------------------------------------------

    // stall pattern redrawn at random from ready_tick: always ready, coin flip,
    // one cycle in three, or mostly ready
    always @(posedge clk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 64 == 0) begin
            ready_mode <= $urandom_range(0, 3);
        end
        case (ready_mode)
            0: begin
                word_if.ready <= 1'b1;
            end
            1: begin
                word_if.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                word_if.ready <= (ready_tick % 3 == 0);
            end
            default: begin
                word_if.ready <= ($urandom_range(0, 3) != 0);
            end
        endcase
    end

    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endfunction

    // every accepted word beat is matched against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && word_if.valid && word_if.ready) begin
            if (word_beats_due.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected beat: byte=%02h last=%b status=%0d",
                    word_if.out_byte, word_if.last_of_word, word_if.status));
            end else begin
                beat_due = word_beats_due.pop_front();
                if (word_if.out_byte !== beat_due.out_byte ||
                    word_if.last_of_word !== beat_due.last_of_word ||
                    word_if.status !== beat_due.status) begin
                    report_mismatch($sformatf(
                        {"beat mismatch: exp byte=%02h last=%b status=%0d, ",
                         "got byte=%02h last=%b status=%0d"},
                        beat_due.out_byte, beat_due.last_of_word, beat_due.status,
                        word_if.out_byte, word_if.last_of_word, word_if.status));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // text side and configuration
    // ------------------------------------------------------------------

    // one text beat, sent in bursts of random length with random gaps
    task automatic send_beat(input logic [7:0] ch, input logic eoi);
        if (burst_left == 0) begin
            // now and then no gap at all, so bursts run back to back
            if ($urandom_range(0, 3) != 0) begin
                char_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        char_if.valid        <= 1'b1;
        char_if.char_code    <= ch;
        char_if.end_of_input <= eoi;
        do @(posedge clk); while (!char_if.ready);
        predict_text_byte(ch, eoi);
        text_beats_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_beat(text[i], 1'b0);
        end
    endtask

    // hold the sender until every owed beat is back, then let the parser settle
    task automatic wait_drained();
        char_if.valid <= 1'b0;
        while (word_beats_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // byte order is only written with the converter idle
    task automatic write_byte_order(input logic [1:0] order);
        wait_drained();
        cfg_if.valid      <= 1'b1;
        cfg_if.byte_order <= order;
        do @(posedge clk); while (!cfg_if.ready);
        word_order = order;
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // random text generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 5))
            0: return tnw_pkg::CH_TAB;
            1: return CH_LF;
            2: return CH_VT;
            3: return CH_FF;
            4: return tnw_pkg::CH_CR;
            default: return tnw_pkg::CH_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input int unsigned value);
        if (value < 10) begin
            return tnw_pkg::CH_ZERO + 8'(value);
        end
        return ($urandom_range(0, 1) ? tnw_pkg::CH_LO_A : tnw_pkg::CH_UP_A) + 8'(value - 10);
    endfunction

    // a byte that is no digit, comma or whitespace in the given token kind
    function automatic logic [7:0] pick_stray_char(input logic hex_ok);
        logic [7:0] ch;
        logic [4:0] nib;
        do begin
            ch  = 8'($urandom_range(0, 255));
            nib = hex_nibble(ch);
        end while (is_blank(ch) || ch == tnw_pkg::CH_COMMA || is_dec_digit(ch) ||
                   (hex_ok && nib[4]));
        return ch;
    endfunction

    task automatic send_dec_digits(input int unsigned count);
        send_beat(tnw_pkg::CH_ONE + 8'($urandom_range(0, 8)), 1'b0);
        for (int i = 1; i < count; i++) begin
            send_beat(tnw_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end
    endtask

    task automatic send_hex_digits(input int unsigned count);
        send_beat(tnw_pkg::CH_ZERO, 1'b0);
        send_beat(tnw_pkg::CH_X, 1'b0);
        for (int i = 0; i < count; i++) begin
            send_beat(hex_char($urandom_range(0, 15)), 1'b0);
        end
    endtask

    // one well-formed token with its terminator, or some harmless noise;
    // always leaves the converter between tokens
    task automatic send_random_token();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            // mostly short numbers, sometimes long enough to wrap
            send_dec_digits(($urandom_range(0, 5) == 0) ? $urandom_range(9, 14)
                                                         : $urandom_range(1, 4));
        end else if (kind <= 7) begin
            // zero digits after 0x gives an empty hex token
            send_hex_digits(($urandom_range(0, 5) == 0) ? $urandom_range(9, 12)
                                                         : $urandom_range(0, 8));
        end
        if (kind <= 8) begin
            // terminator; for kind 8 a lone comma between tokens, a zero word
            send_beat(($urandom_range(0, 1) || kind == 8) ? tnw_pkg::CH_COMMA
                                                          : random_blank(), 1'b0);
        end else begin
            // end of input between tokens, char code ignored
            send_beat(8'($urandom_range(0, 255)), 1'b1);
        end
        repeat ($urandom_range(0, 2)) send_beat(random_blank(), 1'b0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked tokens at the reset byte order
    task automatic test_directed_tokens();
        send_text(",");             // comma between tokens gives zero
        send_text("9 ");
        send_text("0x\t");          // empty hex token gives zero
        send_text("0xAf");          // mixed-case hex digits
        send_beat(CH_VT, 1'b0);
        send_text("4294967295");    // largest word
        send_beat(CH_FF, 1'b0);
        send_beat(tnw_pkg::CH_ONE + 8'd4, 1'b1); // end between tokens: nothing, stays live
        send_text("\n,");           // blank run then another zero word
    endtask

    // random text under every byte order, undefined code and reset value included
    task automatic test_random_text_all_orders();
        logic [1:0]  orders[ORDER_PHASES];
        int unsigned phase_start;
        orders = '{tnw_pkg::BO_BIG, BO_UNDEF, tnw_pkg::BO_LITTLE, tnw_pkg::BO_HOST,
                   tnw_pkg::BO_HOST};
        orders[ORDER_PHASES-1] = 2'($urandom_range(0, 3));
        for (int p = 0; p < ORDER_PHASES; p++) begin
            write_byte_order(orders[p]);
            phase_start = text_beats_sent;
            while (text_beats_sent - phase_start < RANDOM_BEATS / ORDER_PHASES) begin
                send_random_token();
                // occasional full drain in the middle of a phase
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained();
                end
            end
        end
    endtask

    // one error of a random kind, then the dead converter must stay silent
    task automatic test_halt_after_error();
        logic [7:0] ch;
        wait_drained();
        case ($urandom_range(0, 5))
            0: begin
                // stray first byte of a token
                send_beat(pick_stray_char(1'b0), 1'b0);
            end
            1: begin
                // stray byte inside a decimal token
                send_dec_digits($urandom_range(1, 3));
                send_beat(pick_stray_char(1'b0), 1'b0);
            end
            2: begin
                // stray byte inside a hex token
                send_hex_digits($urandom_range(0, 3));
                send_beat(pick_stray_char(1'b1), 1'b0);
            end
            3: begin
                // leading zero not followed by lower-case x
                send_beat(tnw_pkg::CH_ZERO, 1'b0);
                do ch = 8'($urandom_range(0, 255)); while (ch == tnw_pkg::CH_X);
                send_beat(ch, 1'b0);
            end
            4: begin
                // leading zero then end of input
                send_beat(tnw_pkg::CH_ZERO, 1'b0);
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                // end of input inside a number
                if ($urandom_range(0, 1)) begin
                    send_dec_digits($urandom_range(1, 4));
                end else begin
                    send_hex_digits($urandom_range(0, 4));
                end
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        wait_drained();
        // everything after the error is swallowed, high bytes included
        for (int k = 0; k < 16; k++) begin
            ch    = 8'($urandom_range(0, 255));
            ch[7] = k[0];
            send_beat(ch, 1'($urandom_range(0, 3) == 0));
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n                <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.byte_order    <= tnw_pkg::BO_HOST;
        char_if.valid        <= 1'b0;
        char_if.char_code    <= 8'h00;
        char_if.end_of_input <= 1'b0;
        text_mode  = tnw_pkg::MODE_SKIP;
        number_acc = 32'd0;
        word_order = tnw_pkg::BO_HOST;

        // synchronous reset, applied once
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_tokens();
        test_random_text_all_orders();
        test_halt_after_error();

        // drain whatever is owed, then watch a little longer for strays
        char_if.valid <= 1'b0;
        while (word_beats_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
